[rtl/core/owrc_pkg.sv]
`timescale 1ns / 1ps

package owrc_pkg;

  localparam int unsigned ADDR_BITS_DEF     = 16;
  localparam int unsigned PENDING_DEPTH_DEF = 32;

  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned WIR_W     = 13;

  typedef logic [ADDR_W-1:0] addr_t;

  // input modes
  localparam logic [1:0] MODE_DATA   = 2'd0;
  localparam logic [1:0] MODE_WINDOW = 2'd1;
  localparam logic [1:0] MODE_RESET  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS_IN_RING = 2'd2;

  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST   = 16'd256;
  localparam logic [CFG_W-1:0] OVERLAP_LENGTH_RST  = 16'd0;
  localparam logic [WIR_W-1:0] WINDOWS_IN_RING_RST = 13'd4;
  localparam logic [WIR_W-1:0] MAX_WINDOWS         = 13'd4096;

  typedef enum logic [2:0] {
    KIND_WRITE      = 3'd0,
    KIND_RELEASE    = 3'd1,
    KIND_COPY       = 3'd2,
    KIND_PUSHED     = 3'd3,
    KIND_RESET_DONE = 3'd4,
    KIND_FAULT      = 3'd5
  } kind_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [7:0] sync_tag;
    logic       has_sync;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    addr_t       address;
    logic [7:0]  write_data;
    logic        window_done;
    logic [31:0] window_number;
    addr_t       window_start;
    logic [7:0]  release_tag;
    addr_t       space_left;
    logic        last;
  } out_item_t;

  // one queued window
  typedef struct packed {
    logic       has_sync;
    logic [7:0] tag;
    addr_t      start;
  } pend_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } q_ctl_t;

endpackage

[rtl/core/owrc_queue.sv]
`timescale 1ns / 1ps

module owrc_queue #(
  parameter int unsigned DEPTH = owrc_pkg::PENDING_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  owrc_pkg::q_ctl_t           ctl_i,
  input  owrc_pkg::pend_entry_t      wr_entry_i,
  output owrc_pkg::pend_entry_t      head_entry_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  owrc_pkg::pend_entry_t mem_q [DEPTH];
  owrc_pkg::pend_entry_t rd_q;
  owrc_pkg::pend_entry_t byp_data_q;
  logic                  byp_q;

  logic [IW-1:0] head_q, head_d, head_nxt, tail;
  logic [CW-1:0] count_q, count_d;
  logic [CW:0]   tail_sum;

  assign tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
  assign tail     = (tail_sum >= (CW+1)'(DEPTH)) ? IW'(tail_sum - (CW+1)'(DEPTH))
                                                 : IW'(tail_sum);
  assign head_nxt = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctl_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else begin
      if (ctl_i.pop) begin
        head_d = head_nxt;
      end
      if (ctl_i.push && !ctl_i.pop) begin
        count_d = count_q + 1'b1;
      end else if (ctl_i.pop && !ctl_i.push) begin
        count_d = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      byp_q   <= ctl_i.push && (tail == head_d);
    end
  end

  // read port always follows the next head; a write to that entry is forwarded
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[tail] <= wr_entry_i;
    end
    rd_q       <= mem_q[head_d];
    byp_data_q <= wr_entry_i;
  end

  assign head_entry_o = byp_q ? byp_data_q : rd_q;
  assign count_o      = count_q;

endmodule

[rtl/core/overlapping_window_ring_controller.sv]
`timescale 1ns / 1ps
// Data byte push: result registered in the cycle after the transfer, one item per cycle
// while the output is not stalled. Window push: queued, then queued windows are released
// (queue memory read port, one entry per cycle, held while a tagged release waits for the
// output), plus the overlap copy on a wrap, then the result. Reset item: queued windows
// drained, then the reset-done result. After rst_ni and every register write, CALC1 to CALC3
// compute the capacity (one multiply, stalled input); pointers cleared, whole ring free.
module overlapping_window_ring_controller #(
  parameter int unsigned ADDR_BITS     = owrc_pkg::ADDR_BITS_DEF,
  parameter int unsigned PENDING_DEPTH = owrc_pkg::PENDING_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  owrc_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output owrc_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [owrc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [owrc_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int unsigned PW    = ADDR_BITS + 1;
  localparam int unsigned CW    = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned CAP_W = (ADDR_BITS + 2 > 30) ? ADDR_BITS + 2 : 30;
  localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(1) << ADDR_BITS;

  localparam logic [2:0] ST_CALC1 = 3'd0;
  localparam logic [2:0] ST_CALC2 = 3'd1;
  localparam logic [2:0] ST_CALC3 = 3'd2;
  localparam logic [2:0] ST_IDLE  = 3'd3;
  localparam logic [2:0] ST_WRAP  = 3'd4;
  localparam logic [2:0] ST_REL   = 3'd5;
  localparam logic [2:0] ST_DRAIN = 3'd6;

  // configuration
  logic [owrc_pkg::CFG_W-1:0] wl_q, ol_q;
  logic [owrc_pkg::WIR_W-1:0] wir_q;
  logic                       cfg_hit;

  // derived geometry
  logic [28:0]      prod_q;
  logic             neg_q;
  logic [CAP_W-1:0] cap_wide;
  logic [PW-1:0]    cap_q, wl_x_q, ol_x_q, s_q, cap_m_ol_q, cap_m_wl_q;
  logic             cfg_ok_q;
  logic [owrc_pkg::WIR_W-1:0] n_windows;
  logic [owrc_pkg::CFG_W-1:0] len_diff;

  // pointers
  logic [2:0]           st_q, st_d;
  logic [PW-1:0]        dt_q, dt_d, wt_q, wt_d, end_q, end_d, ft_q, ft_d;
  logic [31:0]          cnt_q, cnt_d;
  owrc_pkg::addr_t      start_q, start_d;

  // queue
  owrc_pkg::q_ctl_t      q_ctl;
  owrc_pkg::pend_entry_t q_wr, head_entry;
  logic [CW-1:0]         q_count;

  // output stage
  logic                 out_valid_q;
  owrc_pkg::out_item_t  out_q, res, rel_item;
  logic                 emit, out_free, in_acc, rel_step;

  logic          inv_ok, base_fault, item_fault;
  logic [PW-1:0] ft_step, ft_rel, wr_avail, wr_room, sp_avail, sp_room;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        owrc_pkg::CFG_WINDOW_LENGTH,
        owrc_pkg::CFG_OVERLAP_LENGTH,
        owrc_pkg::CFG_WINDOWS_IN_RING: cfg_hit = 1'b1;
        default:                       cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q  <= owrc_pkg::WINDOW_LENGTH_RST;
      ol_q  <= owrc_pkg::OVERLAP_LENGTH_RST;
      wir_q <= owrc_pkg::WINDOWS_IN_RING_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        owrc_pkg::CFG_WINDOW_LENGTH:   wl_q  <= cfg_data_i;
        owrc_pkg::CFG_OVERLAP_LENGTH:  ol_q  <= cfg_data_i;
        owrc_pkg::CFG_WINDOWS_IN_RING: wir_q <= owrc_pkg::WIR_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // capacity = wl + (wir - 1) * (wl - ol); a negative shift is carried as a sign
  assign n_windows = (wir_q == '0) ? '0 : wir_q - 1'b1;
  assign len_diff  = (ol_q > wl_q) ? ol_q - wl_q : wl_q - ol_q;
  assign cap_wide  = CAP_W'(wl_q) + (neg_q ? CAP_W'(0) - CAP_W'(prod_q) : CAP_W'(prod_q));

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_CALC1: begin
        prod_q <= n_windows * len_diff;
        neg_q  <= ol_q > wl_q;
      end
      ST_CALC2: begin
        cap_q  <= PW'(cap_wide);
        wl_x_q <= PW'(wl_q);
        ol_x_q <= PW'(ol_q);
        s_q    <= PW'(wl_q) - PW'(ol_q);
      end
      ST_CALC3: begin
        cap_m_ol_q <= cap_q - ol_x_q;
        cap_m_wl_q <= cap_q - wl_x_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ok_q <= 1'b0;
    end else if (st_q == ST_CALC2) begin
      cfg_ok_q <= (wl_q != '0) && (ol_q < wl_q) && (wir_q != '0) &&
                  (wir_q <= owrc_pkg::MAX_WINDOWS) && (cap_wide <= CAP_LIMIT);
    end
  end

  owrc_queue #(
    .DEPTH (PENDING_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (q_ctl),
    .wr_entry_i   (q_wr),
    .head_entry_o (head_entry),
    .count_o      (q_count)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (st_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign inv_ok = !(dt_q > cap_q) && !(ft_q < s_q) && !(ft_q > cap_q) &&
                  !(wt_q > cap_m_wl_q) && !(dt_q > ft_q);
  assign base_fault = !cfg_ok_q || !inv_ok;

  always_comb begin
    case (in_item_i.mode)
      owrc_pkg::MODE_RESET:  item_fault = 1'b0;
      owrc_pkg::MODE_DATA:   item_fault = base_fault || (dt_q >= ft_q) || (dt_q >= end_q);
      owrc_pkg::MODE_WINDOW: item_fault = base_fault || (q_count >= CW'(PENDING_DEPTH));
      default:               item_fault = 1'b1;
    endcase
  end

  // free top after one release; the last window of the ring frees everything
  assign ft_step = ft_q + s_q;
  assign ft_rel  = (ft_step == cap_m_ol_q) ? cap_q : ft_step;

  // room after one more byte: a + ~b is a - b - 1
  assign wr_avail = ft_q + ~dt_q;
  assign wr_room  = end_q + ~dt_q;
  assign sp_avail = ft_q - dt_q;
  assign sp_room  = end_q - dt_q;

  assign q_wr.has_sync = in_item_i.has_sync;
  assign q_wr.tag      = in_item_i.sync_tag;
  assign q_wr.start    = owrc_pkg::addr_t'(wt_q);

  always_comb begin
    rel_item               = '0;
    rel_item.kind          = owrc_pkg::KIND_RELEASE;
    rel_item.window_number = cnt_q;
    rel_item.window_start  = head_entry.start;
    rel_item.release_tag   = head_entry.tag;
  end

  always_comb begin
    st_d     = st_q;
    dt_d     = dt_q;
    wt_d     = wt_q;
    end_d    = end_q;
    ft_d     = ft_q;
    cnt_d    = cnt_q;
    start_d  = start_q;
    q_ctl    = '0;
    emit     = 1'b0;
    res      = '0;
    rel_step = 1'b0;
    case (st_q)
      ST_CALC1: st_d = ST_CALC2;
      ST_CALC2: st_d = ST_CALC3;
      ST_CALC3: begin
        ft_d  = cap_q;
        end_d = wl_x_q;
        st_d  = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (item_fault) begin
            emit     = 1'b1;
            res.kind = owrc_pkg::KIND_FAULT;
            res.last = 1'b1;
          end else if (in_item_i.mode == owrc_pkg::MODE_DATA) begin
            emit              = 1'b1;
            res.kind          = owrc_pkg::KIND_WRITE;
            res.address       = owrc_pkg::addr_t'(dt_q);
            res.write_data    = in_item_i.data_byte;
            res.window_done   = (dt_q + PW'(1)) == end_q;
            res.window_number = cnt_q;
            res.window_start  = owrc_pkg::addr_t'(wt_q);
            res.space_left    = owrc_pkg::addr_t'((wr_avail < wr_room) ? wr_avail : wr_room);
            res.last          = 1'b1;
            dt_d              = dt_q + PW'(1);
          end else if (in_item_i.mode == owrc_pkg::MODE_WINDOW) begin
            q_ctl.push = 1'b1;
            start_d    = owrc_pkg::addr_t'(wt_q);
            if (end_q == cap_q) begin
              // ring wraps: tops back to the front
              dt_d  = '0;
              wt_d  = '0;
              end_d = wl_x_q;
              ft_d  = '0;
              st_d  = (ol_x_q != '0) ? ST_WRAP : ST_REL;
            end else begin
              dt_d  = end_q;
              wt_d  = wt_q + s_q;
              end_d = end_q + s_q;
              st_d  = ST_REL;
            end
          end else begin
            st_d = ST_DRAIN;
          end
        end
      end
      ST_WRAP: begin
        if (ft_q <= ol_x_q) begin
          if (!head_entry.has_sync || out_free) begin
            rel_step  = 1'b1;
            q_ctl.pop = 1'b1;
            ft_d      = ft_rel;
            if (head_entry.has_sync) begin
              emit = 1'b1;
              res  = rel_item;
            end
          end
        end else if (out_free) begin
          emit              = 1'b1;
          res.kind          = owrc_pkg::KIND_COPY;
          res.window_number = cnt_q;
          res.window_start  = owrc_pkg::addr_t'(cap_m_ol_q);
          dt_d              = ol_x_q;
          st_d              = ST_REL;
        end
      end
      ST_REL: begin
        if (ft_q < end_q) begin
          if (!head_entry.has_sync || out_free) begin
            rel_step  = 1'b1;
            q_ctl.pop = 1'b1;
            ft_d      = ft_rel;
            if (head_entry.has_sync) begin
              emit = 1'b1;
              res  = rel_item;
            end
          end
        end else if (out_free) begin
          emit              = 1'b1;
          res.kind          = owrc_pkg::KIND_PUSHED;
          res.address       = owrc_pkg::addr_t'(dt_q);
          res.window_number = cnt_q + 32'd1;
          res.window_start  = start_q;
          res.space_left    = owrc_pkg::addr_t'((sp_avail < sp_room) ? sp_avail : sp_room);
          res.last          = 1'b1;
          cnt_d             = cnt_q + 32'd1;
          st_d              = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (q_count != '0) begin
          if (!head_entry.has_sync || out_free) begin
            q_ctl.pop = 1'b1;
            if (head_entry.has_sync) begin
              emit = 1'b1;
              res  = rel_item;
            end
          end
        end else if (out_free) begin
          emit        = 1'b1;
          res.kind    = owrc_pkg::KIND_RESET_DONE;
          res.last    = 1'b1;
          dt_d        = '0;
          wt_d        = '0;
          end_d       = wl_x_q;
          ft_d        = cap_q;
          cnt_d       = '0;
          q_ctl.clear = 1'b1;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
    // a register write clears the pointers and recomputes the geometry
    if (cfg_hit) begin
      st_d        = ST_CALC1;
      dt_d        = '0;
      wt_d        = '0;
      cnt_d       = '0;
      q_ctl       = '0;
      q_ctl.clear = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_CALC1;
      dt_q    <= '0;
      wt_q    <= '0;
      end_q   <= '0;
      ft_q    <= '0;
      cnt_q   <= '0;
      start_q <= '0;
    end else begin
      st_q    <= st_d;
      dt_q    <= dt_d;
      wt_q    <= wt_d;
      end_q   <= end_d;
      ft_q    <= ft_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // the released window must start where the free region ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_step |-> (head_entry.start == owrc_pkg::addr_t'(ft_q)))
    else $error("released window start does not match free top");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ctl.pop |-> (q_count != '0))
    else $error("release from an empty window queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res.last && !cfg_hit) |=> (st_q == ST_IDLE))
    else $error("final result of an item left the sequencer busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> in_stall_o)
    else $error("input taken while geometry is being recomputed");

endmodule

[test/overlapping_window_ring_controller_tb.sv]
`timescale 1ns / 1ps

module overlapping_window_ring_controller_tb;
  import owrc_pkg::*;

  localparam int unsigned QDEPTH = PENDING_DEPTH_DEF;
  localparam int unsigned ABITS = ADDR_BITS_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  overlapping_window_ring_controller u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  // ring pointer shadow and its configuration
  bit [15:0] win_len;
  bit [15:0] ovl_len;
  bit [12:0] ring_wins;
  bit [63:0] wr_ptr, free_ptr, win_ptr;
  bit [31:0] win_total;
  bit [63:0] q_start [QDEPTH];
  bit [8:0]  q_tag [QDEPTH];
  int unsigned q_head, q_fill;
  bit step_bad;

  out_item_t step_out[$];
  out_item_t expected_results[$];
  in_item_t stim_q[$];

  int errors = 0;
  int items_taken = 0;
  int results_seen = 0;
  int kind_tally [8];
  bit in_xfer = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  bit want_hold = 1'b0;
  bit hold_begun = 1'b0;
  int hold_left = 0;
  int pat_left = 0;
  stall_style_e stall_style = STALL_NONE;

  function automatic bit [63:0] ring_cap();
    bit [63:0] n, s, wl;
    wl = win_len;
    s = wl - ovl_len;
    n = (ring_wins != 0) ? ring_wins - 1 : 0;
    return wl + n * s;
  endfunction

  function automatic bit cfg_ok();
    if (win_len == 0 || ovl_len >= win_len) return 1'b0;
    if (ring_wins == 0 || ring_wins > MAX_WINDOWS) return 1'b0;
    return ring_cap() <= (64'd1 << ABITS);
  endfunction

  function automatic bit [63:0] room_now();
    bit [63:0] avail, used, room, wl;
    wl = win_len;
    avail = (free_ptr >= wr_ptr) ? free_ptr - wr_ptr : 0;
    used = (wr_ptr >= win_ptr) ? wr_ptr - win_ptr : 0;
    room = (wl >= used) ? wl - used : 0;
    return (avail < room) ? avail : room;
  endfunction

  function automatic bit ptrs_ok();
    bit [63:0] c, s, wl;
    c = ring_cap();
    wl = win_len;
    s = wl - ovl_len;
    if (wr_ptr > c || free_ptr < s || free_ptr > c) return 1'b0;
    if (win_ptr > c - wl) return 1'b0;
    return wr_ptr <= free_ptr;
  endfunction

  function automatic void clear_ring();
    wr_ptr = 0;
    free_ptr = ring_cap() & ((64'd2 << ABITS) - 64'd1);
    win_ptr = 0;
    win_total = 0;
    q_head = 0;
    q_fill = 0;
  endfunction

  function automatic void add_result(kind_e k, bit [63:0] addr, bit [7:0] wdata, bit done,
                                     bit [31:0] num, bit [63:0] start, bit [7:0] tag,
                                     bit [63:0] space);
    out_item_t r;
    r.kind = k;
    r.address = addr[15:0];
    r.write_data = wdata;
    r.window_done = done;
    r.window_number = num;
    r.window_start = start[15:0];
    r.release_tag = tag;
    r.space_left = space[15:0];
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void release_oldest();
    bit [63:0] st, c, s;
    bit [8:0] tg;
    if (q_fill == 0) begin
      step_bad = 1'b1;
      return;
    end
    st = q_start[q_head];
    tg = q_tag[q_head];
    q_head = (q_head + 1) % QDEPTH;
    q_fill--;
    if (st != free_ptr) begin
      step_bad = 1'b1;
      return;
    end
    if (tg[8]) add_result(KIND_RELEASE, 0, 0, 0, win_total, st, tg[7:0], 0);
    c = ring_cap();
    s = win_len;
    s = s - ovl_len;
    free_ptr += s;
    if (free_ptr == c - ovl_len) free_ptr = c;
  endfunction

  function automatic void enqueue_window(bit [8:0] tg);
    bit [63:0] c, st, wl, ol;
    int unsigned slot;
    c = ring_cap();
    st = win_ptr;
    wl = win_len;
    ol = ovl_len;
    if (q_fill >= QDEPTH) begin
      step_bad = 1'b1;
      return;
    end
    slot = (q_head + q_fill) % QDEPTH;
    q_start[slot] = win_ptr;
    q_tag[slot] = tg;
    q_fill++;
    wr_ptr = win_ptr + wl;
    win_ptr += wl - ol;
    if (wr_ptr == c) begin
      // wrap: free the front for the overlap, then copy the tail bytes there
      wr_ptr = 0;
      free_ptr = 0;
      win_ptr = 0;
      if (ol != 0) begin
        while (!step_bad && free_ptr <= ol) release_oldest();
        if (step_bad) return;
        add_result(KIND_COPY, 0, 0, 0, win_total, c - ol, 0, 0);
        wr_ptr += ol;
      end
    end
    while (!step_bad && free_ptr < win_ptr + wl) release_oldest();
    if (step_bad) return;
    win_total++;
    if (!ptrs_ok()) begin
      step_bad = 1'b1;
      return;
    end
    add_result(KIND_PUSHED, wr_ptr, 0, 0, win_total, st, 0, room_now());
  endfunction

  task automatic predict_step(in_item_t it);
    bit [63:0] s_wr, s_free, s_win, wend;
    bit [31:0] s_total;
    int unsigned s_head, s_fill;
    out_item_t r;
    s_wr = wr_ptr;
    s_free = free_ptr;
    s_win = win_ptr;
    s_total = win_total;
    s_head = q_head;
    s_fill = q_fill;
    step_out.delete();
    step_bad = 1'b0;
    if (it.mode == MODE_RESET) begin
      while (q_fill > 0) begin
        if (q_tag[q_head][8])
          add_result(KIND_RELEASE, 0, 0, 0, win_total, q_start[q_head], q_tag[q_head][7:0], 0);
        q_head = (q_head + 1) % QDEPTH;
        q_fill--;
      end
      clear_ring();
      add_result(KIND_RESET_DONE, 0, 0, 0, 0, 0, 0, 0);
    end else if (it.mode == MODE_UNUSED || !cfg_ok() || !ptrs_ok()) begin
      step_bad = 1'b1;
    end else if (it.mode == MODE_DATA) begin
      wend = win_ptr + win_len;
      if (wr_ptr + 1 > free_ptr || wr_ptr + 1 > wend) begin
        step_bad = 1'b1;
      end else begin
        wr_ptr++;
        add_result(KIND_WRITE, wr_ptr - 1, it.data_byte, wr_ptr == wend, win_total, win_ptr,
                   0, room_now());
      end
    end else begin
      enqueue_window({it.has_sync, it.sync_tag});
    end
    if (step_bad) begin
      wr_ptr = s_wr;
      free_ptr = s_free;
      win_ptr = s_win;
      win_total = s_total;
      q_head = s_head;
      q_fill = s_fill;
      step_out.delete();
      add_result(KIND_FAULT, 0, 0, 0, 0, 0, 0, 0);
    end
    r = step_out.pop_back();
    r.last = 1'b1;
    step_out.push_back(r);
    foreach (step_out[i]) expected_results.push_back(step_out[i]);
  endtask

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: result transfer with nothing expected, expected none, got kind %0d addr %0h",
               $time, got.kind, got.address);
      return;
    end
    want = expected_results.pop_front();
    cmp_field("kind", want.kind, got.kind);
    cmp_field("address", want.address, got.address);
    cmp_field("write_data", want.write_data, got.write_data);
    cmp_field("window_done", want.window_done, got.window_done);
    cmp_field("window_number", want.window_number, got.window_number);
    cmp_field("window_start", want.window_start, got.window_start);
    cmp_field("release_tag", want.release_tag, got.release_tag);
    cmp_field("space_left", want.space_left, got.space_left);
    cmp_field("last", want.last, got.last);
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    in_xfer = rst_n && in_valid && !in_stall;
    if (in_xfer) begin
      predict_step(in_item);
      items_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      kind_tally[out_item.kind]++;
      check_result(out_item);
    end
  end

  // sender: bursts with random gaps, payload held until the transfer
  always @(negedge clk) begin
    if (in_valid && !in_xfer) begin
      // hold the offered item
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (stim_q.size() > 0) begin
      in_item <= stim_q.pop_front();
      in_valid <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: own stall pattern plus one long hold-off
  always @(negedge clk) begin
    if (want_hold && !hold_begun) begin
      hold_begun = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        stall_style = stall_style_e'($urandom_range(0, 3));
        pat_left = $urandom_range(20, 80);
      end
      pat_left--;
      case (stall_style)
        STALL_NONE: out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= pat_left[2];
      endcase
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_WINDOW_LENGTH: win_len = val;
      CFG_OVERLAP_LENGTH: ovl_len = val;
      CFG_WINDOWS_IN_RING: ring_wins = val[WIR_W-1:0];
      default: ;
    endcase
    clear_ring();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_ring(int wl, int ol, int nw);
    write_reg(CFG_WINDOW_LENGTH, CFG_W'(wl));
    write_reg(CFG_OVERLAP_LENGTH, CFG_W'(ol));
    write_reg(CFG_WINDOWS_IN_RING, CFG_W'(nw));
  endtask

  task automatic queue_item(logic [1:0] mode, logic [7:0] data, logic [7:0] tag, logic sync);
    in_item_t it;
    it.mode = mode;
    it.data_byte = data;
    it.sync_tag = tag;
    it.has_sync = sync;
    stim_q.push_back(it);
  endtask

  task automatic queue_random(logic [1:0] mode);
    queue_item(mode, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
  endtask

  // mostly well-formed: fill the window, then push it; some noise on top
  task automatic gen_items(int n, int wl, int ol, int early_pct);
    int need, r;
    need = wl;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        queue_random(MODE_RESET);
        need = wl;
      end else if (r < 6) begin
        queue_random(MODE_UNUSED);
      end else if (r < 10) begin
        queue_random(MODE_DATA);
        if (need > 0) need--;
      end else if (r < 10 + early_pct || need == 0) begin
        queue_random(MODE_WINDOW);
        need = wl - ol;
      end else begin
        queue_random(MODE_DATA);
        need--;
      end
    end
  endtask

  task automatic wait_drained();
    while (stim_q.size() != 0 || in_valid || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    int wl, ol, nw;
    win_len = WINDOW_LENGTH_RST;
    ovl_len = OVERLAP_LENGTH_RST;
    ring_wins = WINDOWS_IN_RING_RST;
    clear_ring();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // defaults after reset: field extremes, every mode, reported release on reset
    queue_item(MODE_DATA, 8'h00, 8'h00, 1'b0);
    queue_item(MODE_DATA, 8'hFF, 8'hFF, 1'b1);
    queue_item(MODE_WINDOW, 8'h00, 8'hFF, 1'b1);
    queue_item(MODE_WINDOW, 8'hFF, 8'h00, 1'b0);
    queue_item(MODE_UNUSED, 8'h5A, 8'hA5, 1'b1);
    queue_item(MODE_RESET, 8'h00, 8'h00, 1'b0);
    wait_drained();

    // small ring with overlap: window overrun, then a wrap with copy
    set_ring(4, 1, 3);
    repeat (4) queue_random(MODE_DATA);
    queue_item(MODE_WINDOW, 8'h00, 8'h5A, 1'b1);
    repeat (3) queue_random(MODE_DATA);
    queue_random(MODE_DATA);
    queue_item(MODE_WINDOW, 8'h00, 8'hA5, 1'b1);
    repeat (3) queue_random(MODE_DATA);
    queue_item(MODE_WINDOW, 8'h00, 8'h3C, 1'b0);
    wait_drained();

    // bad settings: overlap not below window, ring too large, zero and oversize count
    set_ring(8, 8, 2);
    queue_random(MODE_DATA);
    queue_random(MODE_WINDOW);
    queue_random(MODE_RESET);
    wait_drained();
    set_ring(65535, 0, 2);
    queue_random(MODE_WINDOW);
    wait_drained();
    set_ring(16, 0, 0);
    queue_random(MODE_DATA);
    wait_drained();
    set_ring(16, 0, 5000);
    queue_random(MODE_WINDOW);
    wait_drained();

    // largest window with a one-byte shift, ring of exactly the full address space
    set_ring(65535, 65534, 2);
    queue_item(MODE_WINDOW, 8'h00, 8'h81, 1'b1);
    queue_random(MODE_DATA);
    queue_item(MODE_WINDOW, 8'h00, 8'h42, 1'b1);
    queue_random(MODE_DATA);
    wait_drained();

    // random part; the long receiver hold-off lands in the first phase
    set_ring(6, 2, 5);
    want_hold = 1'b1;
    gen_items(40, 6, 2, 5);
    wait_drained();

    set_ring(5, 0, 3);
    gen_items(20, 5, 0, 5);
    wait_drained();

    // one-byte windows: the pending queue overflows before the ring wraps
    set_ring(1, 0, 40);
    repeat (34) queue_random(MODE_WINDOW);
    gen_items(10, 1, 0, 30);
    wait_drained();

    set_ring(7, 6, 9);
    gen_items(20, 7, 6, 5);
    wait_drained();

    wl = $urandom_range(2, 12);
    ol = $urandom_range(0, wl - 1);
    nw = $urandom_range(1, 8);
    set_ring(wl, ol, nw);
    gen_items(20, wl, ol, 8);
    wait_drained();

    repeat (20) @(negedge clk);
    $display("Covered %0d input transfers and %0d result transfers over several ring settings",
             items_taken, results_seen);
    $display("Results: %0d writes, %0d releases, %0d copies, %0d pushes, %0d resets, %0d faults",
             kind_tally[KIND_WRITE], kind_tally[KIND_RELEASE], kind_tally[KIND_COPY],
             kind_tally[KIND_PUSHED], kind_tally[KIND_RESET_DONE], kind_tally[KIND_FAULT]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
rtl/core/owrc_pkg.sv
rtl/core/owrc_queue.sv
rtl/core/overlapping_window_ring_controller.sv
test/overlapping_window_ring_controller_tb.sv
